[sv/ssh_pkg.sv]
`default_nettype none
package ssh_pkg;

  // Stream geometry
  localparam int WINDOW_SAMPLES = 512;
  localparam int SAMPLE_RATE    = 16000;
  localparam int POS_BITS       = 32;
  localparam int MS_PER_S       = 1000;

  // Field widths
  localparam int PROB_W    = 16;
  localparam int MS_W      = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  // Fall threshold in auto mode: max(rise - FALL_OFFSET, FALL_FLOOR)
  localparam int FALL_OFFSET = 9830;
  localparam int FALL_FLOOR  = 655;

  // Register reset values
  localparam logic [PROB_W-1:0] RISE_RST        = PROB_W'(32768);
  localparam logic [PROB_W-1:0] FALL_RST        = PROB_W'(22938);
  localparam int                MIN_SPEECH_MS_RST  = 250;
  localparam int                MIN_SILENCE_MS_RST = 100;
  localparam int                PAD_MS_RST         = 30;

  // Millisecond to sample conversion: floor(ms * SAMPLE_RATE / 1000) by
  // reciprocal multiply, exact for every 16-bit ms value
  localparam int SMP_MAX = ((2 ** MS_W - 1) * SAMPLE_RATE) / MS_PER_S;
  localparam int SMP_W   = $clog2(SMP_MAX + 1);
  localparam int MS_SHIFT = MS_W + 10;
  localparam logic [63:0] MS_K64 =
    ((64'(SAMPLE_RATE) << MS_SHIFT) + 64'(MS_PER_S - 1)) / 64'(MS_PER_S);
  localparam int MS_K_W    = $clog2(MS_K64 + 64'd1);
  localparam logic [MS_K_W-1:0] MS_K = MS_K_W'(MS_K64);
  localparam int MS_PROD_W = MS_W + MS_K_W;

  localparam logic [SMP_W-1:0] MIN_SPEECH_RST =
    SMP_W'((MIN_SPEECH_MS_RST * SAMPLE_RATE) / MS_PER_S);
  localparam logic [SMP_W-1:0] MIN_SILENCE_RST =
    SMP_W'((MIN_SILENCE_MS_RST * SAMPLE_RATE) / MS_PER_S);
  localparam logic [SMP_W-1:0] PAD_RST =
    SMP_W'((PAD_MS_RST * SAMPLE_RATE) / MS_PER_S);

  // Signed working width for position arithmetic
  localparam int WIDE_W = POS_BITS + 2;
  typedef logic signed [WIDE_W-1:0] wide_t;

  // Command queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RISE,
    CFG_FALL,
    CFG_FALL_AUTO,
    CFG_MIN_SPEECH,
    CFG_MIN_SILENCE,
    CFG_PAD
  } cfg_idx_t;

  typedef struct packed {
    logic [PROB_W-1:0] rise;
    logic [PROB_W-1:0] fall;
    logic [SMP_W-1:0]  min_speech;
    logic [SMP_W-1:0]  min_silence;
    logic [SMP_W-1:0]  pad;
  } cfg_t;

  // fin = 0: confirmed segment (s, e)
  // fin = 1: end of stream, e holds total length; has_seg adds segment (s, e)
  typedef struct packed {
    logic                fin;
    logic                has_seg;
    logic [POS_BITS-1:0] s;
    logic [POS_BITS-1:0] e;
  } cmd_t;

  function automatic wide_t wpos(input logic [POS_BITS-1:0] v);
    return wide_t'({2'b00, v});
  endfunction

  function automatic wide_t wsmp(input logic [SMP_W-1:0] v);
    return wide_t'({{(WIDE_W - SMP_W){1'b0}}, v});
  endfunction

  function automatic logic [POS_BITS-1:0] max0(input wide_t v);
    return v[WIDE_W-1] ? '0 : v[POS_BITS-1:0];
  endfunction

endpackage
`default_nettype wire

[sv/ssh_cfg.sv]
`default_nettype none
module ssh_cfg (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          wr_en,
  input  wire [ssh_pkg::CFG_IDX_W-1:0] wr_index,
  input  wire [ssh_pkg::CFG_DAT_W-1:0] wr_data,
  output ssh_pkg::cfg_t                cfg
);
  import ssh_pkg::*;

  logic [PROB_W-1:0]    rise_r;
  logic [PROB_W-1:0]    fall_r;
  logic                 fall_auto_r;
  logic [SMP_W-1:0]     min_speech_r;
  logic [SMP_W-1:0]     min_silence_r;
  logic [SMP_W-1:0]     pad_r;
  logic [MS_PROD_W-1:0] prod;
  logic [SMP_W-1:0]     smp;

  // convert the written milliseconds on the way in
  assign prod = MS_PROD_W'(wr_data[MS_W-1:0]) * MS_PROD_W'(MS_K);
  assign smp  = prod[MS_SHIFT +: SMP_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rise_r        <= RISE_RST;
      fall_r        <= FALL_RST;
      fall_auto_r   <= 1'b1;
      min_speech_r  <= MIN_SPEECH_RST;
      min_silence_r <= MIN_SILENCE_RST;
      pad_r         <= PAD_RST;
    end else if (wr_en) begin
      case (wr_index)
        CFG_RISE:        rise_r        <= wr_data[PROB_W-1:0];
        CFG_FALL:        fall_r        <= wr_data[PROB_W-1:0];
        CFG_FALL_AUTO:   fall_auto_r   <= wr_data[0];
        CFG_MIN_SPEECH:  min_speech_r  <= smp;
        CFG_MIN_SILENCE: min_silence_r <= smp;
        CFG_PAD:         pad_r         <= smp;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.rise        = rise_r;
    cfg.min_speech  = min_speech_r;
    cfg.min_silence = min_silence_r;
    cfg.pad         = pad_r;
    if (!fall_auto_r) begin
      cfg.fall = fall_r;
    end else if (rise_r < PROB_W'(FALL_OFFSET + FALL_FLOOR)) begin
      cfg.fall = PROB_W'(FALL_FLOOR);
    end else begin
      cfg.fall = rise_r - PROB_W'(FALL_OFFSET);
    end
  end

endmodule
`default_nettype wire

[sv/ssh_front.sv]
`default_nettype none
module ssh_front (
  input  wire                         clk,
  input  wire                         rst_n,
  input  ssh_pkg::cfg_t               cfg,
  input  wire                         accept,
  input  wire [ssh_pkg::PROB_W-1:0]   probability,
  input  wire                         finish,
  input  wire [ssh_pkg::POS_BITS-1:0] total_samples,
  output logic                        push,
  output ssh_pkg::cmd_t               cmd
);
  import ssh_pkg::*;

  logic                in_speech_r, in_speech_nxt;
  logic [POS_BITS-1:0] open_r, open_nxt;
  logic [POS_BITS-1:0] silence_r, silence_nxt;
  logic [POS_BITS-1:0] wpos_r, wpos_nxt;
  logic [POS_BITS:0]   pos_sum;
  logic [POS_BITS-1:0] pos_inc;
  logic                p_hi, p_lo;

  assign p_hi    = probability >= cfg.rise;
  assign p_lo    = probability < cfg.fall;
  assign pos_sum = {1'b0, wpos_r} + (POS_BITS + 1)'(WINDOW_SAMPLES);
  assign pos_inc = pos_sum[POS_BITS] ? '1 : pos_sum[POS_BITS-1:0];

  always_comb begin
    logic [POS_BITS-1:0] sb;
    sb            = silence_r;
    in_speech_nxt = in_speech_r;
    open_nxt      = open_r;
    silence_nxt   = silence_r;
    wpos_nxt      = wpos_r;
    push          = 1'b0;
    cmd           = '0;
    if (accept) begin
      if (finish) begin
        push        = 1'b1;
        cmd.fin     = 1'b1;
        cmd.has_seg = in_speech_r &&
                      (wpos(total_samples) - wpos(open_r) > wsmp(cfg.min_speech));
        cmd.s       = open_r;
        cmd.e       = total_samples;
        in_speech_nxt = 1'b0;
        open_nxt      = '0;
        silence_nxt   = '0;
        wpos_nxt      = '0;
      end else begin
        wpos_nxt = pos_inc;
        if (p_hi) begin
          sb = '0;
        end
        if (p_hi && !in_speech_r) begin
          in_speech_nxt = 1'b1;
          open_nxt      = wpos_r;
        end else if (p_lo && in_speech_r) begin
          if (sb == '0) begin
            sb = wpos_r;
          end
          // close once silence has lasted long enough; keep only long segments
          if (wpos(wpos_r) - wpos(sb) >= wsmp(cfg.min_silence)) begin
            if (wpos(sb) - wpos(open_r) > wsmp(cfg.min_speech)) begin
              push  = 1'b1;
              cmd.s = open_r;
              cmd.e = sb;
            end
            open_nxt      = '0;
            sb            = '0;
            in_speech_nxt = 1'b0;
          end
        end
        silence_nxt = sb;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_speech_r <= 1'b0;
      open_r      <= '0;
      silence_r   <= '0;
      wpos_r      <= '0;
    end else begin
      in_speech_r <= in_speech_nxt;
      open_r      <= open_nxt;
      silence_r   <= silence_nxt;
      wpos_r      <= wpos_nxt;
    end
  end

endmodule
`default_nettype wire

[sv/ssh_queue.sv]
`default_nettype none
module ssh_queue (
  input  wire           clk,
  input  wire           rst_n,
  input  wire           push,
  input  ssh_pkg::cmd_t push_cmd,
  input  wire           pop,
  output ssh_pkg::cmd_t head,
  output logic          empty,
  output logic          full
);
  import ssh_pkg::*;

  cmd_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign head  = mem_r[rd_ptr_r];
  assign empty = count_r == '0;
  assign full  = count_r == QCNT_W'(QDEPTH);

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule
`default_nettype wire

[sv/ssh_back.sv]
`default_nettype none
module ssh_back (
  input  wire                         clk,
  input  wire                         rst_n,
  input  ssh_pkg::cfg_t               cfg,
  input  wire                         q_valid,
  input  ssh_pkg::cmd_t               head,
  output logic                        pop,
  output logic                        out_valid,
  input  wire                         out_ready,
  output logic [ssh_pkg::POS_BITS-1:0] seg_start,
  output logic [ssh_pkg::POS_BITS-1:0] seg_end,
  output logic                        no_segment,
  output logic                        last_of_run
);
  import ssh_pkg::*;

  typedef enum logic {ST_CMD, ST_LAST} state_t;

  state_t              state_r, state_nxt;
  logic                pv_r, pv_nxt;
  logic [POS_BITS-1:0] ps_r, ps_nxt;
  logic [POS_BITS-1:0] pend_r, pend_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [POS_BITS-1:0] start_r, start_nxt;
  logic [POS_BITS-1:0] end_r, end_nxt;
  logic                noseg_r, noseg_nxt;
  logic                last_r, last_nxt;

  wide_t               pad, gap, half, acc_pe, fin_e;
  logic                acc_emit;
  logic [POS_BITS-1:0] acc_ps, acc_ns;
  logic                go;

  // padding against the pending segment
  always_comb begin
    pad      = wsmp(cfg.pad);
    gap      = wpos(head.s) - wpos(pend_r);
    half     = (gap + wide_t'({{(WIDE_W - 1){1'b0}}, gap[WIDE_W-1]})) >>> 1;
    acc_emit = pv_r;
    if (!pv_r) begin
      acc_pe = '0;
      acc_ns = max0(wpos(head.s) - pad);
    end else if (gap < (pad <<< 1)) begin
      // neighbors too close: split the gap
      acc_pe = wpos(pend_r) + half;
      acc_ns = max0(wpos(head.s) - half);
    end else begin
      acc_pe = wpos(pend_r) + pad;
      acc_ns = max0(wpos(head.s) - pad);
    end
    acc_ps = ps_r;
    fin_e  = wpos(pend_r) + pad;
    if (fin_e > wpos(head.e)) begin
      fin_e = wpos(head.e);
    end
  end

  assign go = q_valid && (!out_valid_r || out_ready);

  always_comb begin
    logic do_acc, do_fin;
    do_acc        = 1'b0;
    do_fin        = 1'b0;
    state_nxt     = state_r;
    pop           = 1'b0;
    pv_nxt        = pv_r;
    ps_nxt        = ps_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r && !out_ready;
    start_nxt     = start_r;
    end_nxt       = end_r;
    noseg_nxt     = noseg_r;
    last_nxt      = last_r;
    case (state_r)
      ST_CMD: begin
        if (go) begin
          if (!head.fin) begin
            do_acc = 1'b1;
            pop    = 1'b1;
          end else if (head.has_seg) begin
            do_acc    = 1'b1;
            state_nxt = ST_LAST;
          end else begin
            do_fin = 1'b1;
            pop    = 1'b1;
          end
        end
      end
      ST_LAST: begin
        if (go) begin
          do_fin    = 1'b1;
          pop       = 1'b1;
          state_nxt = ST_CMD;
        end
      end
      default: state_nxt = ST_CMD;
    endcase

    if (do_acc) begin
      pv_nxt   = 1'b1;
      ps_nxt   = acc_ns;
      pend_nxt = head.e;
      if (acc_emit) begin
        out_valid_nxt = 1'b1;
        start_nxt     = acc_ps;
        end_nxt       = acc_pe[POS_BITS-1:0];
        noseg_nxt     = 1'b0;
        last_nxt      = 1'b0;
      end
    end
    if (do_fin) begin
      out_valid_nxt = 1'b1;
      last_nxt      = 1'b1;
      noseg_nxt     = !pv_r;
      start_nxt     = pv_r ? ps_r : '0;
      end_nxt       = pv_r ? fin_e[POS_BITS-1:0] : '0;
      pv_nxt        = 1'b0;
      ps_nxt        = '0;
      pend_nxt      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CMD;
      pv_r        <= 1'b0;
      ps_r        <= '0;
      pend_r      <= '0;
      out_valid_r <= 1'b0;
      start_r     <= '0;
      end_r       <= '0;
      noseg_r     <= 1'b0;
      last_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pv_r        <= pv_nxt;
      ps_r        <= ps_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      start_r     <= start_nxt;
      end_r       <= end_nxt;
      noseg_r     <= noseg_nxt;
      last_r      <= last_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign seg_start   = start_r;
  assign seg_end     = end_r;
  assign no_segment  = noseg_r;
  assign last_of_run = last_r;

endmodule
`default_nettype wire

[sv/speech_segment_hysteresis.sv]
`default_nettype none
// channel  direction  handshake              payload
// in       sink       in_valid / in_ready    probability, finish, total_samples
// out      source     out_valid / out_ready  seg_start, seg_end, no_segment, last_of_run
// cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_wdata
//
// One input beat per cycle while in_ready is high; the front updates hysteresis
// state in the cycle it takes a beat. The back drains a 4-entry command queue at
// one command per cycle while out_ready does not stall it; a finish that closes a
// kept segment first pads it against the pending segment (emitting that one if
// present), then gives the last result. Results leave from an output register.
// in_ready drops only while the command queue is full. cfg_ready is always high.
// Synchronous reset, no clearing pass; all but the queue storage return to defaults.
module speech_segment_hysteresis (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire [ssh_pkg::PROB_W-1:0]    in_probability,
  input  wire                          in_finish,
  input  wire [ssh_pkg::POS_BITS-1:0]  in_total_samples,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [ssh_pkg::POS_BITS-1:0] out_seg_start,
  output logic [ssh_pkg::POS_BITS-1:0] out_seg_end,
  output logic                         out_no_segment,
  output logic                         out_last_of_run,
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire [ssh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire [ssh_pkg::CFG_DAT_W-1:0] cfg_wdata
);
  import ssh_pkg::*;

  cfg_t cfg;
  cmd_t push_cmd;
  cmd_t head;
  logic push, pop, q_empty, q_full, in_acc;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign in_acc    = in_valid && in_ready;

  ssh_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_wdata),
    .cfg      (cfg)
  );

  ssh_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .accept        (in_acc),
    .probability   (in_probability),
    .finish        (in_finish),
    .total_samples (in_total_samples),
    .push          (push),
    .cmd           (push_cmd)
  );

  ssh_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  ssh_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .q_valid     (!q_empty),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .seg_start   (out_seg_start),
    .seg_end     (out_seg_end),
    .no_segment  (out_no_segment),
    .last_of_run (out_last_of_run)
  );

  // an empty-stream result is always the last one and carries no positions
  a_noseg_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_no_segment |->
      out_last_of_run && out_seg_start == '0 && out_seg_end == '0)
    else $error("no_segment result malformed");

  // a finish beat always leaves a command behind
  a_finish_queued: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_finish |=> !q_empty)
    else $error("finish beat not queued");

  // results only come from queued commands
  a_out_from_queue: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid && q_empty |=> !out_valid)
    else $error("result without a command");

endmodule
`default_nettype wire
